// ----- rtl/gnss_binary_frame_parser_core_defines.svh -----
// Assertion macros shared by the parser core.
// Each check runs on clk_i and is disabled while rst_ni is low.
`ifndef GNSS_BINARY_FRAME_PARSER_CORE_DEFINES_SVH
`define GNSS_BINARY_FRAME_PARSER_CORE_DEFINES_SVH

// Same-cycle implication.
`define GBFP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gbfp: same-cycle check failed");

// Next-cycle implication.
`define GBFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gbfp: next-cycle check failed");

`endif

// ----- rtl/gbfp_pkg.sv -----
package gbfp_pkg;

  localparam int unsigned MaxPayload  = 100;
  localparam int unsigned CounterBits = 16;
  localparam int unsigned CountOutW   = 16;
  localparam int unsigned ShadowDepth = 24;

  localparam logic [7:0]  SyncOne = 8'hB5;
  localparam logic [7:0]  SyncTwo = 8'h62;
  localparam logic [15:0] TypePv  = 16'h0107;
  localparam logic [15:0] TypeDop = 16'h0104;
  localparam int unsigned FixBit  = 0;

  // Shadow slots of the fields that get decoded.
  localparam int unsigned SlotHdop   = 0;
  localparam int unsigned SlotFlags  = 2;
  localparam int unsigned SlotSats   = 3;
  localparam int unsigned SlotLon    = 4;
  localparam int unsigned SlotLat    = 8;
  localparam int unsigned SlotAlt    = 12;
  localparam int unsigned SlotSpeed  = 16;
  localparam int unsigned SlotCourse = 20;

  // Reciprocals for exact truncating division of a magnitude up to 2^31:
  // q = (x * Recip) >> Shift.
  localparam logic [31:0] Recip10    = 32'd3435973837;
  localparam int unsigned Shift10    = 35;
  localparam logic [31:0] Recip100   = 32'd2748779070;
  localparam int unsigned Shift100   = 38;
  localparam logic [31:0] Recip10k   = 32'd3518437209;
  localparam int unsigned Shift10k   = 45;

  localparam int unsigned PosW    = 64 - Shift10;
  localparam int unsigned SpeedW  = 64 - Shift100;
  localparam int unsigned AltW    = 64 - Shift100;
  localparam int unsigned CourseW = 64 - Shift10k;

  typedef logic [ShadowDepth-1:0][7:0] shadow_t;

  typedef enum logic [11:0] {
    StHunt    = 12'b0000_0000_0001,
    StSync2   = 12'b0000_0000_0010,
    StClass   = 12'b0000_0000_0100,
    StId      = 12'b0000_0000_1000,
    StLenLo   = 12'b0000_0001_0000,
    StLenHi   = 12'b0000_0010_0000,
    StPayload = 12'b0000_0100_0000,
    StCkA     = 12'b0000_1000_0000,
    StCkB     = 12'b0001_0000_0000,
    StSkip    = 12'b0010_0000_0000,
    StSkipCkA = 12'b0100_0000_0000,
    StSkipCkB = 12'b1000_0000_0000
  } parse_state_e;

  typedef struct packed {
    logic flag;
    logic upd_pv;
    logic upd_dop;
  } frame_evt_t;

  typedef struct packed {
    logic signed [SpeedW-1:0]  speed;
    logic signed [CourseW-1:0] course;
    logic signed [PosW-1:0]    lon;
    logic signed [PosW-1:0]    lat;
    logic signed [AltW-1:0]    alt;
  } quot_t;

  // Shadow slot for a payload offset: {hit, slot}.
  function automatic logic [5:0] shadow_slot(logic [15:0] pos);
    logic [4:0] slot;
    logic       hit;
    hit  = 1'b1;
    slot = '0;
    priority if (pos == 16'd12 || pos == 16'd13) begin
      slot = 5'(pos - 16'd12);
    end else if (pos == 16'd21) begin
      slot = 5'(SlotFlags);
    end else if (pos == 16'd23) begin
      slot = 5'(SlotSats);
    end else if (pos >= 16'd24 && pos <= 16'd31) begin
      slot = 5'(pos - 16'd20);
    end else if (pos >= 16'd36 && pos <= 16'd39) begin
      slot = 5'(pos - 16'd24);
    end else if (pos >= 16'd60 && pos <= 16'd67) begin
      slot = 5'(pos - 16'd44);
    end else begin
      hit = 1'b0;
    end
    return {hit, slot};
  endfunction

endpackage

// ----- rtl/gbfp_parser.sv -----
module gbfp_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   beat_i,
  input  logic [7:0]             rx_byte_i,
  output gbfp_pkg::shadow_t      shadow_o,
  output gbfp_pkg::frame_evt_t   evt_o,
  output logic [gbfp_pkg::CountOutW-1:0] error_count_o,
  output logic [gbfp_pkg::CountOutW-1:0] packet_count_o
);

  gbfp_pkg::parse_state_e state_q, state_d;
  logic [15:0] type_q, type_d;
  logic [15:0] len_q, len_d;
  logic [15:0] pos_q, pos_d;
  logic [7:0]  sum_a_q, sum_a_d;
  logic [7:0]  sum_b_q, sum_b_d;
  logic [gbfp_pkg::CounterBits-1:0] err_q, good_q;
  gbfp_pkg::shadow_t shadow_q;

  logic [7:0]  add_a, add_b;
  logic [15:0] pos_inc;
  logic [15:0] len_new;
  logic [5:0]  slot_info;
  logic        shadow_we;
  logic        err_inc;
  logic        good_inc;

  assign add_a     = sum_a_q + rx_byte_i;
  assign add_b     = sum_b_q + add_a;
  assign pos_inc   = pos_q + 16'd1;
  assign len_new   = {rx_byte_i, len_q[7:0]};
  assign slot_info = gbfp_pkg::shadow_slot(pos_q);

  always_comb begin
    state_d   = state_q;
    type_d    = type_q;
    len_d     = len_q;
    pos_d     = pos_q;
    sum_a_d   = sum_a_q;
    sum_b_d   = sum_b_q;
    shadow_we = 1'b0;
    err_inc   = 1'b0;
    good_inc  = 1'b0;
    evt_o     = '0;
    if (beat_i) begin
      unique case (state_q)
        gbfp_pkg::StSync2: begin
          state_d = (rx_byte_i == gbfp_pkg::SyncTwo) ? gbfp_pkg::StClass : gbfp_pkg::StHunt;
        end
        gbfp_pkg::StClass: begin
          sum_a_d = rx_byte_i;
          sum_b_d = rx_byte_i;
          type_d  = {rx_byte_i, 8'h00};
          state_d = gbfp_pkg::StId;
        end
        gbfp_pkg::StId: begin
          sum_a_d = add_a;
          sum_b_d = add_b;
          type_d  = {type_q[15:8], rx_byte_i};
          state_d = gbfp_pkg::StLenLo;
        end
        gbfp_pkg::StLenLo: begin
          sum_a_d = add_a;
          sum_b_d = add_b;
          len_d   = {8'h00, rx_byte_i};
          state_d = gbfp_pkg::StLenHi;
        end
        gbfp_pkg::StLenHi: begin
          sum_a_d = add_a;
          sum_b_d = add_b;
          len_d   = len_new;
          pos_d   = '0;
          if (len_new == 16'd0) begin
            state_d = gbfp_pkg::StCkA;
          end else if ((type_q != gbfp_pkg::TypePv && type_q != gbfp_pkg::TypeDop) ||
                       len_new > 16'(gbfp_pkg::MaxPayload)) begin
            state_d = gbfp_pkg::StSkip;
          end else begin
            state_d = gbfp_pkg::StPayload;
          end
        end
        gbfp_pkg::StPayload: begin
          sum_a_d   = add_a;
          sum_b_d   = add_b;
          shadow_we = slot_info[5];
          pos_d     = pos_inc;
          if (pos_inc >= len_q) begin
            state_d = gbfp_pkg::StCkA;
          end
        end
        gbfp_pkg::StCkA, gbfp_pkg::StSkipCkA: begin
          if (rx_byte_i == sum_a_q) begin
            state_d = (state_q == gbfp_pkg::StCkA) ? gbfp_pkg::StCkB : gbfp_pkg::StSkipCkB;
          end else begin
            err_inc = 1'b1;
            state_d = gbfp_pkg::StHunt;
          end
        end
        gbfp_pkg::StCkB, gbfp_pkg::StSkipCkB: begin
          if (rx_byte_i == sum_b_q) begin
            good_inc      = 1'b1;
            evt_o.flag    = 1'b1;
            evt_o.upd_pv  = (state_q == gbfp_pkg::StCkB) && (type_q == gbfp_pkg::TypePv);
            evt_o.upd_dop = (state_q == gbfp_pkg::StCkB) && (type_q == gbfp_pkg::TypeDop);
          end else begin
            err_inc = 1'b1;
          end
          state_d = gbfp_pkg::StHunt;
        end
        gbfp_pkg::StSkip: begin
          sum_a_d = add_a;
          sum_b_d = add_b;
          pos_d   = pos_inc;
          if (pos_inc >= len_q) begin
            state_d    = gbfp_pkg::StSkipCkA;
            evt_o.flag = 1'b1;
          end
        end
        default: begin
          state_d = (rx_byte_i == gbfp_pkg::SyncOne) ? gbfp_pkg::StSync2 : gbfp_pkg::StHunt;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= gbfp_pkg::StHunt;
      type_q   <= '0;
      len_q    <= '0;
      pos_q    <= '0;
      sum_a_q  <= '0;
      sum_b_q  <= '0;
      err_q    <= '0;
      good_q   <= '0;
      shadow_q <= '0;
    end else begin
      state_q <= state_d;
      type_q  <= type_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
      if (err_inc) begin
        err_q <= err_q + gbfp_pkg::CounterBits'(1);
      end
      if (good_inc) begin
        good_q <= good_q + gbfp_pkg::CounterBits'(1);
      end
      if (shadow_we) begin
        shadow_q[slot_info[4:0]] <= rx_byte_i;
      end
    end
  end

  logic [31:0] err_ext, good_ext;
  assign err_ext        = 32'(err_q);
  assign good_ext       = 32'(good_q);
  assign error_count_o  = err_ext[gbfp_pkg::CountOutW-1:0];
  assign packet_count_o = good_ext[gbfp_pkg::CountOutW-1:0];
  assign shadow_o       = shadow_q;

endmodule

// ----- rtl/gbfp_quot.sv -----
module gbfp_quot (
  input  logic              clk_i,
  input  gbfp_pkg::shadow_t shadow_i,
  output gbfp_pkg::quot_t   quot_o
);

  function automatic logic [31:0] word_at(gbfp_pkg::shadow_t sh, logic [4:0] slot);
    return {sh[slot + 5'd3], sh[slot + 5'd2], sh[slot + 5'd1], sh[slot]};
  endfunction

  function automatic logic [31:0] magnitude(logic [31:0] w);
    return w[31] ? (~w + 32'd1) : w;
  endfunction

  logic [31:0] w_speed, w_course, w_lon, w_lat, w_alt;
  logic [63:0] p_speed, p_course, p_lon, p_lat, p_alt;

  logic [gbfp_pkg::SpeedW-1:0]  speed_mag_q;
  logic [gbfp_pkg::CourseW-1:0] course_mag_q;
  logic [gbfp_pkg::PosW-1:0]    lon_mag_q, lat_mag_q;
  logic [gbfp_pkg::AltW-1:0]    alt_mag_q;
  logic [4:0]                   neg_q;

  always_comb begin
    w_speed  = word_at(shadow_i, 5'(gbfp_pkg::SlotSpeed));
    w_course = word_at(shadow_i, 5'(gbfp_pkg::SlotCourse));
    w_lon    = word_at(shadow_i, 5'(gbfp_pkg::SlotLon));
    w_lat    = word_at(shadow_i, 5'(gbfp_pkg::SlotLat));
    w_alt    = word_at(shadow_i, 5'(gbfp_pkg::SlotAlt));
    p_speed  = 64'(magnitude(w_speed))  * 64'(gbfp_pkg::Recip100);
    p_course = 64'(magnitude(w_course)) * 64'(gbfp_pkg::Recip10k);
    p_lon    = 64'(magnitude(w_lon))    * 64'(gbfp_pkg::Recip10);
    p_lat    = 64'(magnitude(w_lat))    * 64'(gbfp_pkg::Recip10);
    p_alt    = 64'(magnitude(w_alt))    * 64'(gbfp_pkg::Recip100);
  end

  // Track the shadow bytes every cycle; the quotients settle in the cycle after a write.
  always_ff @(posedge clk_i) begin
    speed_mag_q  <= p_speed[63:gbfp_pkg::Shift100];
    course_mag_q <= p_course[63:gbfp_pkg::Shift10k];
    lon_mag_q    <= p_lon[63:gbfp_pkg::Shift10];
    lat_mag_q    <= p_lat[63:gbfp_pkg::Shift10];
    alt_mag_q    <= p_alt[63:gbfp_pkg::Shift100];
    neg_q        <= {w_speed[31], w_course[31], w_lon[31], w_lat[31], w_alt[31]};
  end

  // Restore the sign: truncation toward zero.
  always_comb begin
    quot_o.speed  = neg_q[4] ? (~speed_mag_q + gbfp_pkg::SpeedW'(1)) : speed_mag_q;
    quot_o.course = neg_q[3] ? (~course_mag_q + gbfp_pkg::CourseW'(1)) : course_mag_q;
    quot_o.lon    = neg_q[2] ? (~lon_mag_q + gbfp_pkg::PosW'(1)) : lon_mag_q;
    quot_o.lat    = neg_q[1] ? (~lat_mag_q + gbfp_pkg::PosW'(1)) : lat_mag_q;
    quot_o.alt    = neg_q[0] ? (~alt_mag_q + gbfp_pkg::AltW'(1)) : alt_mag_q;
  end

endmodule

// ----- rtl/gbfp_result.sv -----
module gbfp_result (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 beat_i,
  input  logic                 out_stall_i,
  input  gbfp_pkg::frame_evt_t evt_i,
  input  gbfp_pkg::shadow_t    shadow_i,
  input  gbfp_pkg::quot_t      quot_i,
  output logic                 out_valid_o,
  output logic                 frame_flag_o,
  output logic                 fix_valid_o,
  output logic [7:0]           sat_count_o,
  output logic signed [gbfp_pkg::SpeedW-1:0]  ground_speed_o,
  output logic signed [gbfp_pkg::CourseW-1:0] course_o,
  output logic signed [gbfp_pkg::PosW-1:0]    longitude_o,
  output logic signed [gbfp_pkg::PosW-1:0]    latitude_o,
  output logic signed [gbfp_pkg::AltW-1:0]    altitude_o,
  output logic [15:0]          hdop_o
);

  logic valid_q, flag_q, fix_q;
  logic [7:0]  sat_q;
  logic [15:0] hdop_q;
  logic signed [gbfp_pkg::SpeedW-1:0]  speed_q;
  logic signed [gbfp_pkg::CourseW-1:0] course_q;
  logic signed [gbfp_pkg::PosW-1:0]    lon_q, lat_q;
  logic signed [gbfp_pkg::AltW-1:0]    alt_q;
  logic fix_new;

  assign fix_new = shadow_i[gbfp_pkg::SlotFlags][gbfp_pkg::FixBit];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      flag_q   <= 1'b0;
      fix_q    <= 1'b0;
      sat_q    <= '0;
      speed_q  <= '0;
      course_q <= '0;
      lon_q    <= '0;
      lat_q    <= '0;
      alt_q    <= '0;
      hdop_q   <= '0;
    end else begin
      if (beat_i) begin
        valid_q <= 1'b1;
        flag_q  <= evt_i.flag;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
      if (beat_i && evt_i.upd_pv) begin
        fix_q    <= fix_new;
        sat_q    <= shadow_i[gbfp_pkg::SlotSats];
        speed_q  <= quot_i.speed;
        course_q <= quot_i.course;
        if (fix_new) begin
          lon_q <= quot_i.lon;
          lat_q <= quot_i.lat;
          alt_q <= quot_i.alt;
        end
      end
      if (beat_i && evt_i.upd_dop) begin
        hdop_q <= {shadow_i[gbfp_pkg::SlotHdop+1], shadow_i[gbfp_pkg::SlotHdop]};
      end
    end
  end

  assign out_valid_o    = valid_q;
  assign frame_flag_o   = flag_q;
  assign fix_valid_o    = fix_q;
  assign sat_count_o    = sat_q;
  assign ground_speed_o = speed_q;
  assign course_o       = course_q;
  assign longitude_o    = lon_q;
  assign latitude_o     = lat_q;
  assign altitude_o     = alt_q;
  assign hdop_o         = hdop_q;

endmodule

// ----- rtl/gnss_binary_frame_parser_core.sv -----
// Channel  | Direction | Handshake              | Payload
// input    | in        | in_valid_i / in_stall_o  | rx_byte_i
// output   | out       | out_valid_o / out_stall_i| frame_flag_o .. packet_count_o
//
// Cycles: one byte per clock unless stalled; each beat gives its result in the next cycle.
// The byte path is the parser state machine and the checksum adder between registers.
// Divided values come from multiplier registers that track the shadow bytes every clock;
// they settle in the cycle after a shadow write, and the first checksum byte always sits
// between the last write and the second checksum byte that uses them.
// Reset: rst_ni, asynchronous, clears parse state, sums, shadow bytes, values, counters.
// Stalls: hold the input while a result waits and out_stall_i is high; a waiting result
// leaves the same edge a new beat enters.
`include "gnss_binary_frame_parser_core_defines.svh"

module gnss_binary_frame_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        frame_flag_o,
  output logic        fix_valid_o,
  output logic [7:0]  sat_count_o,
  output logic signed [25:0] ground_speed_o,
  output logic signed [18:0] course_o,
  output logic signed [28:0] longitude_o,
  output logic signed [28:0] latitude_o,
  output logic signed [25:0] altitude_o,
  output logic [15:0] hdop_o,
  output logic [15:0] error_count_o,
  output logic [15:0] packet_count_o
);

  logic                 beat;
  gbfp_pkg::shadow_t    shadow;
  gbfp_pkg::frame_evt_t evt;
  gbfp_pkg::quot_t      quot;

  // Stall only while a result waits and the sink holds it.
  assign in_stall_o = out_valid_o & out_stall_i;
  assign beat       = in_valid_i & ~in_stall_o;

  // Frame state machine, Fletcher sums, shadow bytes and frame counters.
  gbfp_parser u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .beat_i         (beat),
    .rx_byte_i      (rx_byte_i),
    .shadow_o       (shadow),
    .evt_o          (evt),
    .error_count_o  (error_count_o),
    .packet_count_o (packet_count_o)
  );

  // Constant dividers: reciprocal multiply, registered, then sign restore.
  gbfp_quot u_quot (
    .clk_i    (clk_i),
    .shadow_i (shadow),
    .quot_o   (quot)
  );

  // Navigation value registers and the output beat.
  gbfp_result u_result (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .beat_i         (beat),
    .out_stall_i    (out_stall_i),
    .evt_i          (evt),
    .shadow_i       (shadow),
    .quot_i         (quot),
    .out_valid_o    (out_valid_o),
    .frame_flag_o   (frame_flag_o),
    .fix_valid_o    (fix_valid_o),
    .sat_count_o    (sat_count_o),
    .ground_speed_o (ground_speed_o),
    .course_o       (course_o),
    .longitude_o    (longitude_o),
    .latitude_o     (latitude_o),
    .altitude_o     (altitude_o),
    .hdop_o         (hdop_o)
  );

  // Every accepted byte yields a result on the next cycle.
  `GBFP_ASSERT_NEXT(a_beat_gives_result, beat, out_valid_o)
  // Without a beat, counters and position stay put.
  `GBFP_ASSERT_NEXT(a_idle_holds, !beat,
    $stable(error_count_o) && $stable(packet_count_o) && $stable(longitude_o))
  // A checksum failure never flags a frame.
  `GBFP_ASSERT_NOW(a_error_no_flag, !$stable(error_count_o), !frame_flag_o)
  // Latitude only moves on a good, fixed position frame.
  `GBFP_ASSERT_NOW(a_lat_needs_fix, !$stable(latitude_o), fix_valid_o && frame_flag_o)

endmodule

// ----- verif/testbench.sv -----
module testbench;
  import gbfp_pkg::*;

  localparam int RandBytes  = 1950;
  localparam int CycleLimit = 100000;
  localparam int QuietFrom  = 1200;  // no idling on either side in this window
  localparam int QuietTo    = 2200;

  // One input beat: the byte, plus an optional typed-in expectation
  // (flag and both counters, every decoded value still zero).
  typedef struct packed {
    logic [7:0]  rx;
    logic        chk;
    logic        flag;
    logic [15:0] errs;
    logic [15:0] pkts;
  } rx_beat_t;

  // One output beat, in port order.
  typedef struct packed {
    logic               flag;
    logic               fix;
    logic [7:0]         sats;
    logic signed [25:0] speed;
    logic signed [18:0] course;
    logic signed [28:0] lon;
    logic signed [28:0] lat;
    logic signed [25:0] alt;
    logic [15:0]        hdop;
    logic [15:0]        errs;
    logic [15:0]        pkts;
  } nav_report_t;

  // Directed bytes right after reset.
  localparam int DirRows = 27;
  localparam rx_beat_t DirTab [DirRows] = '{
    // first sync, then a second first-sync byte: back to hunting, and the
    // byte is not taken as a fresh first sync, so the next 0x62 is noise
    '{SyncOne,         1'b0, 1'b0, 16'd0, 16'd0},
    '{SyncOne,         1'b0, 1'b0, 16'd0, 16'd0},
    '{SyncTwo,         1'b1, 1'b0, 16'd0, 16'd0},
    // empty position frame with a good checksum: decode all-zero shadow
    '{SyncOne,         1'b0, 1'b0, 16'd0, 16'd0},
    '{SyncTwo,         1'b0, 1'b0, 16'd0, 16'd0},
    '{TypePv[15:8],    1'b0, 1'b0, 16'd0, 16'd0},
    '{TypePv[7:0],     1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h00,           1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h00,           1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h08,           1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h19,           1'b1, 1'b1, 16'd0, 16'd1},
    // empty dilution frame, first checksum byte wrong
    '{SyncOne,         1'b0, 1'b0, 16'd0, 16'd0},
    '{SyncTwo,         1'b0, 1'b0, 16'd0, 16'd0},
    '{TypeDop[15:8],   1'b0, 1'b0, 16'd0, 16'd0},
    '{TypeDop[7:0],    1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h00,           1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h00,           1'b0, 1'b0, 16'd0, 16'd0},
    '{8'hFF,           1'b1, 1'b0, 16'd1, 16'd1},
    // unknown type, one payload byte: flag at the end of the skipped
    // payload and again on the good second checksum byte
    '{SyncOne,         1'b0, 1'b0, 16'd0, 16'd0},
    '{SyncTwo,         1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h0A,           1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h0B,           1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h01,           1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h00,           1'b0, 1'b0, 16'd0, 16'd0},
    '{8'hFF,           1'b1, 1'b1, 16'd1, 16'd1},
    '{8'h15,           1'b0, 1'b0, 16'd0, 16'd0},
    '{8'h60,           1'b1, 1'b1, 16'd1, 16'd2}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [7:0]         rx_byte_i = 8'h00;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               frame_flag_o;
  logic               fix_valid_o;
  logic [7:0]         sat_count_o;
  logic signed [25:0] ground_speed_o;
  logic signed [18:0] course_o;
  logic signed [28:0] longitude_o;
  logic signed [28:0] latitude_o;
  logic signed [25:0] altitude_o;
  logic [15:0]        hdop_o;
  logic [15:0]        error_count_o;
  logic [15:0]        packet_count_o;

  gnss_binary_frame_parser_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .frame_flag_o   (frame_flag_o),
    .fix_valid_o    (fix_valid_o),
    .sat_count_o    (sat_count_o),
    .ground_speed_o (ground_speed_o),
    .course_o       (course_o),
    .longitude_o    (longitude_o),
    .latitude_o     (latitude_o),
    .altitude_o     (altitude_o),
    .hdop_o         (hdop_o),
    .error_count_o  (error_count_o),
    .packet_count_o (packet_count_o)
  );

  always #2 clk_i = ~clk_i;

  rx_beat_t    stim_q [$];
  nav_report_t nav_reports_due [$];
  int          fed = 0;
  int          seen = 0;
  int          cycles = 0;
  int          faults = 0;
  int          fixes_seen = 0;

  // ---------------------------------------------------------------------
  // Parser mirror: state, running sums, shadow bytes and decoded values.
  // ---------------------------------------------------------------------
  parse_state_e pars_st = StHunt;
  logic [15:0]  p_type = '0;
  logic [15:0]  p_len = '0;
  logic [15:0]  p_pos = '0;
  logic [7:0]   ck_a = '0;
  logic [7:0]   ck_b = '0;
  logic [7:0]   shadow_b [ShadowDepth] = '{default: 8'h00};
  logic         fix_v = 1'b0;
  logic [7:0]   sats_v = '0;
  int           speed_v = 0;
  int           course_v = 0;
  int           lon_v = 0;
  int           lat_v = 0;
  int           alt_v = 0;
  logic [15:0]  hdop_v = '0;
  logic [15:0]  errs_v = '0;
  logic [15:0]  pkts_v = '0;

  function automatic void fold_sum(logic [7:0] c);
    ck_a += c;
    ck_b += ck_a;
  endfunction

  // Little-endian signed word from four shadow slots.
  function automatic int le_word(int s);
    return int'({shadow_b[s+3], shadow_b[s+2], shadow_b[s+1], shadow_b[s]});
  endfunction

  task automatic parse_rx_byte(input logic [7:0] c, output nav_report_t r);
    logic flag;
    flag = 1'b0;
    case (pars_st)
      StSync2: pars_st = (c == SyncTwo) ? StClass : StHunt;
      StClass: begin
        ck_a = c;
        ck_b = c;
        p_type = {c, 8'h00};
        pars_st = StId;
      end
      StId: begin
        fold_sum(c);
        p_type[7:0] = c;
        pars_st = StLenLo;
      end
      StLenLo: begin
        fold_sum(c);
        p_len = {8'h00, c};
        pars_st = StLenHi;
      end
      StLenHi: begin
        fold_sum(c);
        p_len[15:8] = c;
        p_pos = '0;
        if (p_len == 16'd0) begin
          pars_st = StCkA;
        end else if ((p_type != TypePv && p_type != TypeDop) || p_len > MaxPayload) begin
          pars_st = StSkip;
        end else begin
          pars_st = StPayload;
        end
      end
      StPayload: begin
        fold_sum(c);
        // keep only the offsets that get decoded
        if (p_pos == 16'd12 || p_pos == 16'd13) shadow_b[SlotHdop + p_pos - 12] = c;
        else if (p_pos == 16'd21) shadow_b[SlotFlags] = c;
        else if (p_pos == 16'd23) shadow_b[SlotSats] = c;
        else if (p_pos >= 16'd24 && p_pos <= 16'd31) shadow_b[SlotLon + p_pos - 24] = c;
        else if (p_pos >= 16'd36 && p_pos <= 16'd39) shadow_b[SlotAlt + p_pos - 36] = c;
        else if (p_pos >= 16'd60 && p_pos <= 16'd67) shadow_b[SlotSpeed + p_pos - 60] = c;
        p_pos = p_pos + 16'd1;
        if (p_pos >= p_len) pars_st = StCkA;
      end
      StSkip: begin
        fold_sum(c);
        p_pos = p_pos + 16'd1;
        if (p_pos >= p_len) begin
          pars_st = StSkipCkA;
          flag = 1'b1;
        end
      end
      StCkA, StSkipCkA: begin
        if (c == ck_a) begin
          pars_st = (pars_st == StCkA) ? StCkB : StSkipCkB;
        end else begin
          errs_v = errs_v + 16'd1;
          pars_st = StHunt;
        end
      end
      StCkB, StSkipCkB: begin
        if (c == ck_b) begin
          if (pars_st == StCkB && p_type == TypePv) begin
            fix_v = shadow_b[SlotFlags][FixBit];
            sats_v = shadow_b[SlotSats];
            speed_v = le_word(SlotSpeed) / 100;
            course_v = le_word(SlotCourse) / 10000;
            if (fix_v) begin
              lon_v = le_word(SlotLon) / 10;
              lat_v = le_word(SlotLat) / 10;
              alt_v = le_word(SlotAlt) / 100;
              fixes_seen++;
            end
          end
          if (pars_st == StCkB && p_type == TypeDop) begin
            hdop_v = {shadow_b[SlotHdop+1], shadow_b[SlotHdop]};
          end
          pkts_v = pkts_v + 16'd1;
          flag = 1'b1;
        end else begin
          errs_v = errs_v + 16'd1;
        end
        pars_st = StHunt;
      end
      default: pars_st = (c == SyncOne) ? StSync2 : StHunt;
    endcase
    r = {flag, fix_v, sats_v, speed_v[25:0], course_v[18:0], lon_v[28:0], lat_v[28:0],
         alt_v[25:0], hdop_v, errs_v, pkts_v};
  endtask

  // ---------------------------------------------------------------------
  // Stimulus builders.
  // ---------------------------------------------------------------------
  function automatic void feed(logic [7:0] b);
    rx_beat_t e;
    e = '0;
    e.rx = b;
    stim_q.push_back(e);
  endfunction

  // Pick a 32-bit field value, leaning on the sign and division edges.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_FFFF;
      4: return $urandom_range(20000) - 10000;
      default: return $urandom();
    endcase
  endfunction

  // Append one frame. spoil: 1 breaks the first checksum byte, 2 the second,
  // 3 cuts the frame somewhere after its length field.
  task automatic add_frame(input logic [15:0] ftype, input int len, input int spoil);
    logic [7:0]  body [$];
    logic [7:0]  sa;
    logic [7:0]  sb;
    logic [7:0]  flags;
    logic [31:0] w;
    int          offs [5];
    int          cut;
    body = '{ftype[15:8], ftype[7:0], len[7:0], len[15:8]};
    for (int i = 0; i < len; i++) body.push_back(8'($urandom_range(255)));
    if (ftype == TypePv) begin
      flags = 8'($urandom_range(255));
      flags[FixBit] = ($urandom_range(99) < 65);
      if (len > 21) body[4+21] = flags;
      offs = '{24, 28, 36, 60, 64};
      foreach (offs[j]) begin
        w = pick_word();
        for (int k = 0; k < 4; k++) begin
          if (4 + offs[j] + k < body.size()) body[4+offs[j]+k] = w[8*k +: 8];
        end
      end
    end else if (ftype == TypeDop) begin
      w = pick_word();
      if (len > 12) body[4+12] = w[7:0];
      if (len > 13) body[4+13] = w[15:8];
    end
    sa = '0;
    sb = '0;
    foreach (body[k]) begin
      sa += body[k];
      sb += sa;
    end
    if (spoil == 1) sa ^= 8'($urandom_range(1, 255));
    if (spoil == 2) sb ^= 8'($urandom_range(1, 255));
    cut = (spoil == 3) ? $urandom_range(4, body.size()) : body.size();
    feed(SyncOne);
    feed(SyncTwo);
    for (int i = 0; i < cut; i++) feed(body[i]);
    if (spoil != 3) begin
      feed(sa);
      feed(sb);
    end
  endtask

  task automatic build_stimulus();
    int          pick;
    int          spoil;
    int          len;
    logic [15:0] ftype;
    logic [7:0]  b;
    // walk the directed rows first
    for (int i = 0; i < DirRows; i++) stim_q.push_back(DirTab[i]);
    // then mostly well-formed frames with random content, some noise
    while (stim_q.size() < DirRows + RandBytes) begin
      pick = $urandom_range(99);
      spoil = ($urandom_range(99) < 12) ? $urandom_range(1, 3) : 0;
      ftype = $urandom_range(1) ? TypePv : TypeDop;
      if (pick < 40) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4: len = 92;
          5, 6:          len = $urandom_range(1, MaxPayload);
          7:             len = MaxPayload;
          default:       len = $urandom_range(60, 99);
        endcase
        add_frame(TypePv, len, spoil);
      end else if (pick < 55) begin
        add_frame(TypeDop, $urandom_range(1) ? 18 : $urandom_range(1, MaxPayload), spoil);
      end else if (pick < 65) begin
        ftype = 16'($urandom_range(65535));
        if (ftype == TypePv || ftype == TypeDop) ftype ^= 16'h0100;
        add_frame(ftype, $urandom_range(30), spoil);
      end else if (pick < 72) begin
        // too long to keep: skipped but still summed
        len = ($urandom_range(9) == 0) ? $urandom_range(256, 300)
                                       : $urandom_range(MaxPayload + 1, 140);
        add_frame(ftype, len, spoil);
      end else if (pick < 78) begin
        if ($urandom_range(2) == 0) ftype = 16'($urandom_range(65535));
        add_frame(ftype, 0, spoil);
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 6)) feed(8'($urandom_range(255)));
      end else begin
        // first sync without a proper second one
        feed(SyncOne);
        b = 8'($urandom_range(255));
        if (b == SyncTwo) b = SyncOne;
        feed(b);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Checking.
  // ---------------------------------------------------------------------
  task automatic log_fault(input string what);
    faults++;
    $display("mismatch at result %0d: %s", seen, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) log_fault($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  // Drive the input channel, predict on each accepted byte, and check each
  // accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    nav_report_t want;
    nav_report_t got;
    logic        quiet;
    cycles++;
    quiet = (cycles >= QuietFrom && cycles < QuietTo);
    if (cycles > CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end else if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = {frame_flag_o, fix_valid_o, sat_count_o, ground_speed_o, course_o,
               longitude_o, latitude_o, altitude_o, hdop_o, error_count_o, packet_count_o};
        if (nav_reports_due.size() == 0) begin
          log_fault("result with nothing pending");
        end else begin
          want = nav_reports_due.pop_front();
          check_field("frame_flag", got.flag, want.flag);
          check_field("fix_valid", got.fix, want.fix);
          check_field("sat_count", got.sats, want.sats);
          check_field("ground_speed", got.speed, want.speed);
          check_field("course", got.course, want.course);
          check_field("longitude", got.lon, want.lon);
          check_field("latitude", got.lat, want.lat);
          check_field("altitude", got.alt, want.alt);
          check_field("hdop", got.hdop, want.hdop);
          check_field("error_count", got.errs, want.errs);
          check_field("packet_count", got.pkts, want.pkts);
        end
        seen++;
      end
      if (in_valid_i && !in_stall_o) begin
        parse_rx_byte(stim_q[fed].rx, want);
        // typed-in rows override the mirror's prediction
        if (stim_q[fed].chk) begin
          want = '0;
          want.flag = stim_q[fed].flag;
          want.errs = stim_q[fed].errs;
          want.pkts = stim_q[fed].pkts;
        end
        nav_reports_due.push_back(want);
        fed++;
      end
      // hold a stalled beat; otherwise present the next byte or idle
      if (!in_valid_i || !in_stall_o) begin
        if (fed < stim_q.size() && (quiet || $urandom_range(99) >= 10)) begin
          in_valid_i <= 1'b1;
          rx_byte_i <= stim_q[fed].rx;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= !quiet && ($urandom_range(99) < 10);
    end
  end

  initial begin
    build_stimulus();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (fed < stim_q.size()) @(posedge clk_i);
    while (nav_reports_due.size() != 0) @(posedge clk_i);
    // drain: catch any stray result after the last one
    repeat (8) @(posedge clk_i);
    $display("summary: %0d bytes parsed, %0d good frames, %0d checksum failures",
             fed, pkts_v, errs_v);
    $display("summary: %0d position fixes decoded, %0d result mismatches", fixes_seen, faults);
    if (faults == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
